@@ hw/rtl/b64enc_pkg.sv @@
// Shared types, constants and the character table for the base64 stream encoder.
// Used by every module of the encoder; depends on nothing else.
package b64enc_pkg;

   // Default depth of the queue between front and back.
   localparam int QueueDepth = 4;

   // Padding character '='.
   localparam logic [7:0] PadChar = 8'h3D;

   // Bits per output group.
   localparam int GroupBits = 6;

   // Position within the current 3-byte group.
   typedef enum logic [1:0] {
      PH_0 = 2'd0,
      PH_1 = 2'd1,
      PH_2 = 2'd2
   } phase_type;

   // One input request.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_final;
   } req_type;

   // One result character.
   typedef struct packed {
      logic [7:0] out_char;
      logic       end_of_text;
   } rsp_type;

   // One output slot: either a 6-bit group or a pad character.
   typedef struct packed {
      logic                 pad;
      logic [GroupBits-1:0] value;
   } slot_type;

   // Work for the back part: up to four characters from one byte.
   typedef struct packed {
      slot_type [3:0] slots;
      logic [1:0]     last;
      logic           final_flag;
   } desc_type;

   // Map a 6-bit group onto the standard base64 alphabet.
   function automatic logic [7:0] sym_char(input logic [GroupBits-1:0] v);
      logic [7:0] ext;
      logic [7:0] ch;
      ext = {2'b00, v};
      if (v < 6'd26) begin
         ch = ext + 8'd65;
      end else if (v < 6'd52) begin
         ch = ext + 8'd71;
      end else if (v < 6'd62) begin
         ch = ext - 8'd4;
      end else if (v == 6'd62) begin
         ch = 8'h2B;
      end else begin
         ch = 8'h2F;
      end
      return ch;
   endfunction

endpackage

@@ hw/rtl/b64enc_front.sv @@
// Front part of the encoder: accepts bytes, keeps the group phase and the
// leftover bits, and builds one work descriptor per byte. Uses b64enc_pkg.
module b64enc_front
   import b64enc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_push,
   input  req_type  req_data,
   output logic     req_full,
   input  logic     q_full,
   output logic     q_push,
   output desc_type q_desc
);

   phase_type  phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   phase_type  mid_phase;
   logic [3:0] mid_left;
   logic [7:0] b;

   assign b        = req_data.data_byte;
   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

   // Characters due from this byte and the state it leaves behind.
   always_comb begin
      q_desc    = '0;
      mid_phase = PH_1;
      mid_left  = {2'b00, b[1:0]};
      case (phase_ff)
         PH_1: begin
            q_desc.slots[0].value = {left_ff[1:0], b[7:4]};
            q_desc.last           = 2'd0;
            mid_phase             = PH_2;
            mid_left              = b[3:0];
         end
         PH_2: begin
            q_desc.slots[0].value = {left_ff, b[7:6]};
            q_desc.slots[1].value = b[5:0];
            q_desc.last           = 2'd1;
            mid_phase             = PH_0;
            mid_left              = 4'd0;
         end
         default: begin
            q_desc.slots[0].value = b[7:2];
            q_desc.last           = 2'd0;
         end
      endcase

      // A final byte flushes the partial group and pads to four characters.
      q_desc.final_flag = req_data.is_final;
      if (req_data.is_final) begin
         case (mid_phase)
            PH_1: begin
               q_desc.slots[1].value = {mid_left[1:0], 4'd0};
               q_desc.slots[2].pad   = 1'b1;
               q_desc.slots[3].pad   = 1'b1;
               q_desc.last           = 2'd3;
            end
            PH_2: begin
               q_desc.slots[1].value = {mid_left, 2'd0};
               q_desc.slots[2].pad   = 1'b1;
               q_desc.last           = 2'd2;
            end
            default: begin
               q_desc.last = q_desc.last;
            end
         endcase
      end
   end

   // Next state of the group phase and leftover bits.
   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      if (q_push) begin
         if (req_data.is_final) begin
            phase_in = PH_0;
            left_in  = 4'd0;
         end else begin
            phase_in = mid_phase;
            left_in  = mid_left;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_0;
         left_ff  <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

   // A final byte always returns the front to the start of a group.
   a_final_resets: assert property (@(posedge clock) disable iff (reset)
      q_push && req_data.is_final |=> phase_ff == PH_0 && left_ff == 4'd0)
      else $error("front did not return to phase 0 after a final byte");

endmodule

@@ hw/rtl/b64enc_queue.sv @@
// Short descriptor queue between the front and back parts, held in flops.
// Uses b64enc_pkg for the descriptor type.
module b64enc_queue
   import b64enc_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  desc_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output logic     rd_valid,
   output desc_type rd_data
);

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   desc_type            mem_ff [DEPTH];
   logic [IdxW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_wr, do_rd;

   assign full     = count_ff == CntW'(DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; the count tells which entries are live.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("queue occupancy exceeds its depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      do_wr && !do_rd |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue occupancy did not follow a write");

endmodule

@@ hw/rtl/b64enc_back.sv @@
// Back part of the encoder: walks the slots of the queue head, turns each
// into a character and holds it in the result register. Uses b64enc_pkg.
module b64enc_back
   import b64enc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  desc_type head,
   output logic     head_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load, at_last;
   slot_type   cur;

   assign cur       = head.slots[idx_ff];
   assign at_last   = idx_ff == head.last;
   assign load      = head_valid && (!valid_ff || rsp_pop);
   assign head_pop  = load && at_last;
   assign rsp_empty = !valid_ff;
   assign rsp_data  = rsp_ff;

   // Next character, slot index and result valid.
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (load) begin
         valid_in           = 1'b1;
         rsp_in.out_char    = cur.pad ? PadChar : sym_char(cur.value);
         rsp_in.end_of_text = head.final_flag && at_last;
         idx_in             = at_last ? 2'd0 : idx_ff + 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff <= head.last)
      else $error("slot index beyond the last slot of the head descriptor");

endmodule

@@ hw/rtl/base64_stream_encoder_core.sv @@
// Base64 stream encoder: one byte per request in, one character per result out.
// The first character of a byte passes through the descriptor queue and the result
// register before it reaches the result ports, and it waits there until popped.
// The front takes one byte per cycle until the descriptor queue fills; the result
// register gives one character per cycle while the receiver pops, so the output
// side sets the stream rate. Synchronous active-high reset empties the queue and
// result register and returns the group phase to zero.
module base64_stream_encoder_core
   import b64enc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic     q_full, q_push, q_pop, q_valid;
   desc_type q_desc, q_head;

   // Accept and classify bytes.
   b64enc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_desc   (q_desc)
   );

   // Decouple front and back.
   b64enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  (q_desc),
      .full     (q_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_head)
   );

   // Emit characters.
   b64enc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head       (q_head),
      .head_pop   (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

@@ dv/tb_base64_stream_encoder_core.sv @@
// Testbench for base64_stream_encoder_core: sends byte messages and checks every encoded
// character against a behavioral encoder kept inside this file.
// Depends on b64enc_pkg and the base64_stream_encoder_core RTL.
`timescale 1ns / 1ps

module tb_base64_stream_encoder_core;
   import b64enc_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   // Standard base64 alphabet, indexed by the 6-bit group value.
   string b64_symbols = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // State of the behavioral encoder.
   phase_type  enc_phase = PH_0;
   logic [3:0] enc_leftover = 4'd0;

   // Characters predicted but not yet seen at the output.
   rsp_type expected_chars[$];

   int error_count = 0;
   int bytes_sent = 0;
   int messages_sent = 0;
   int chars_checked = 0;
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   bit hold_pop = 1'b0;

   base64_stream_encoder_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Map a 6-bit group value onto its base64 character.
   function automatic logic [7:0] group_char(input logic [5:0] v);
      return b64_symbols[v];
   endfunction

   // Work out the characters that one accepted byte produces and queue them.
   task automatic predict_chars(input req_type r);
      rsp_type chars[4];
      int      n;
      n = 0;
      case (enc_phase)
         PH_1: begin
            chars[n++] = '{group_char({enc_leftover[1:0], r.data_byte[7:4]}), 1'b0};
            enc_phase = PH_2;
            enc_leftover = r.data_byte[3:0];
         end
         PH_2: begin
            chars[n++] = '{group_char({enc_leftover, r.data_byte[7:6]}), 1'b0};
            chars[n++] = '{group_char(r.data_byte[5:0]), 1'b0};
            enc_phase = PH_0;
            enc_leftover = 4'd0;
         end
         default: begin
            chars[n++] = '{group_char(r.data_byte[7:2]), 1'b0};
            enc_phase = PH_1;
            enc_leftover = {2'b00, r.data_byte[1:0]};
         end
      endcase
      // A final byte flushes the partial group, pads to four characters and restarts.
      if (r.is_final) begin
         if (enc_phase == PH_1) begin
            chars[n++] = '{group_char({enc_leftover[1:0], 4'b0000}), 1'b0};
            chars[n++] = '{PadChar, 1'b0};
            chars[n++] = '{PadChar, 1'b0};
         end else if (enc_phase == PH_2) begin
            chars[n++] = '{group_char({enc_leftover, 2'b00}), 1'b0};
            chars[n++] = '{PadChar, 1'b0};
         end
         chars[n-1].end_of_text = 1'b1;
         enc_phase = PH_0;
         enc_leftover = 4'd0;
      end
      for (int i = 0; i < n; i++) begin
         expected_chars.push_back(chars[i]);
      end
   endtask

   // Offer one byte, idling first at random, and hold it until the block takes it.
   task automatic send_byte(input logic [7:0] value, input logic last);
      req_type r;
      r.data_byte = value;
      r.is_final = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      predict_chars(r);
      bytes_sent++;
      if (last) begin
         messages_sent++;
      end
   endtask

   // Send a message of random bytes; now and then a byte is forced to an extreme.
   task automatic send_random_message(input int len);
      logic [7:0] value;
      for (int i = 0; i < len; i++) begin
         value = 8'($urandom_range(255));
         if ($urandom_range(9) == 0) begin
            value = $urandom_range(1) ? 8'hFF : 8'h00;
         end
         send_byte(value, i == len - 1);
      end
   endtask

   // Stop offering requests and wait until every predicted character has come out.
   task automatic drain;
      req_push <= 1'b0;
      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // Extremes, every length modulo three, and the two rarest symbols.
   task automatic test_directed;
      send_idle_pct = 0;
      pop_stall_pct = 0;
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hA5, 1'b1);
      drain();
   endtask

   // Random messages of mostly short lengths under one idling setting.
   task automatic test_random_messages(input int idle_pct, input int stall_pct,
                                       input int byte_budget);
      int sent_here;
      int len;
      sent_here = 0;
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      while (sent_here < byte_budget) begin
         len = ($urandom_range(7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 7);
         send_random_message(len);
         sent_here += len;
      end
      drain();
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_full_queue;
      send_idle_pct = 0;
      pop_stall_pct = 0;
      fork
         begin
            hold_pop = 1'b1;
            repeat (300) @(posedge clock);
            hold_pop = 1'b0;
         end
         begin
            send_random_message(13);
            send_random_message(11);
         end
      join
      drain();
   endtask

   // Take results at random and compare each with the oldest prediction.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected character, expected none, got char %h eot %b",
                        $time, rsp_data.out_char, rsp_data.end_of_text);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.out_char !== want.out_char) begin
                  $display("%0t: out_char mismatch, expected %h, got %h",
                           $time, want.out_char, rsp_data.out_char);
                  error_count++;
               end
               if (rsp_data.end_of_text !== want.end_of_text) begin
                  $display("%0t: end_of_text mismatch, expected %b, got %b",
                           $time, want.end_of_text, rsp_data.end_of_text);
                  error_count++;
               end
            end
            chars_checked++;
         end
         if (hold_pop) begin
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
         end
      end
   end

   // Test sequence.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_messages(0, 0, 55);
      test_random_messages(64, 0, 55);
      test_random_messages(0, 64, 55);
      test_random_messages(38, 38, 55);
      test_full_queue();
      $display("Encoded %0d bytes in %0d messages and checked %0d characters,",
               bytes_sent, messages_sent, chars_checked);
      $display("with idle and stall phases and one long output hold-off.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
